// File: rtl/xng_pkg.sv
`timescale 1ns / 1ps

package xng_pkg;

  localparam int unsigned BYTES_PER_WORD_DEF = 8;

  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
  localparam logic [15:0] STREAM_STEP  = 16'h9E37;
  localparam logic [7:0]  NOISE_MOD    = 8'd127;
  localparam logic [7:0]  NOISE_OFFSET = 8'd63;

  localparam logic MODE_RESEED   = 1'b0;
  localparam logic MODE_GENERATE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_MIX,
    ST_MUL_A,
    ST_MUL_B,
    ST_ADV
  } seq_state_t;

  // Request from the sequencer to the byte emitter.
  typedef struct packed {
    logic       load;
    logic [3:0] count;
  } emit_req_t;

  // Maps a raw byte to (b mod 127) - 63 as a 7-bit two's complement value.
  function automatic logic [6:0] noise_map(input logic [7:0] b);
    logic [7:0] m;
    logic [7:0] d;
    begin
      if (b >= 2 * NOISE_MOD) begin
        m = b - 8'(2 * NOISE_MOD);
      end else if (b >= NOISE_MOD) begin
        m = b - NOISE_MOD;
      end else begin
        m = b;
      end
      d = m - NOISE_OFFSET;
      return d[6:0];
    end
  endfunction

endpackage

// File: rtl/xng_mul64lo.sv
`timescale 1ns / 1ps

// Low 64 bits of a 64 x 64 product, built from three passes through one
// 32 x 32 multiplier. The operands must hold while run is high; done marks
// the cycle in which prod is valid.
module xng_mul64lo (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        run,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] prod
);

  localparam logic [1:0] PH_LOLO = 2'd0;
  localparam logic [1:0] PH_LOHI = 2'd1;
  localparam logic [1:0] PH_HILO = 2'd2;

  logic [1:0]  phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] op_x, op_y;
  logic [63:0] pp;
  logic [31:0] hi_sum;

  always_comb begin
    case (phase_r)
      PH_LOLO: begin
        op_x = a[31:0];
        op_y = b[31:0];
      end
      PH_LOHI: begin
        op_x = a[31:0];
        op_y = b[63:32];
      end
      PH_HILO: begin
        op_x = a[63:32];
        op_y = b[31:0];
      end
      default: begin
        op_x = '0;
        op_y = '0;
      end
    endcase
  end

  assign pp     = 64'(op_x) * 64'(op_y);
  assign hi_sum = acc_r[63:32] + pp[31:0];

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    done      = 1'b0;
    if (run) begin
      case (phase_r)
        PH_LOLO: begin
          acc_nxt   = pp;
          phase_nxt = PH_LOHI;
        end
        PH_LOHI: begin
          acc_nxt   = {hi_sum, acc_r[31:0]};
          phase_nxt = PH_HILO;
        end
        PH_HILO: begin
          done      = 1'b1;
          phase_nxt = PH_LOLO;
        end
        default: begin
          phase_nxt = PH_LOLO;
        end
      endcase
    end
  end

  assign prod = {hi_sum, acc_r[31:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LOLO;
    end else begin
      phase_r <= phase_nxt;
    end
    acc_r <= acc_nxt;
  end

endmodule

// File: rtl/xng_emit.sv
`timescale 1ns / 1ps

// Holds one generated word and sends its bytes, low byte first, through an
// output register, one transfer per cycle while out_tready is high.
module xng_emit
  import xng_pkg::*;
#(
  parameter int unsigned BYTES_PER_WORD = BYTES_PER_WORD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  emit_req_t   req,
  input  logic [63:0] word,
  output logic        busy,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [6:0]  out_noise,
  output logic        out_tlast
);

  localparam int unsigned WORD_W = 8 * BYTES_PER_WORD;
  localparam logic [3:0]  MAX_CNT = 4'(BYTES_PER_WORD);

  logic [WORD_W-1:0] word_r, word_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic              valid_r, valid_nxt;
  logic [6:0]        noise_r, noise_nxt;
  logic              last_r, last_nxt;
  logic              advance;

  assign busy    = (cnt_r != 4'd0);
  assign advance = busy && (!valid_r || out_tready);

  always_comb begin
    word_nxt  = word_r;
    cnt_nxt   = cnt_r;
    valid_nxt = valid_r;
    noise_nxt = noise_r;
    last_nxt  = last_r;
    if (valid_r && out_tready) begin
      valid_nxt = 1'b0;
    end
    if (advance) begin
      valid_nxt = 1'b1;
      noise_nxt = noise_map(word_r[7:0]);
      last_nxt  = (cnt_r == 4'd1);
      word_nxt  = word_r >> 8;
      cnt_nxt   = cnt_r - 4'd1;
    end else if (req.load) begin
      word_nxt = word[WORD_W-1:0];
      cnt_nxt  = (req.count > MAX_CNT) ? MAX_CNT : req.count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
    word_r  <= word_nxt;
    noise_r <= noise_nxt;
    last_r  <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_noise  = noise_r;
  assign out_tlast  = last_r;

endmodule

// File: rtl/xoshiro_int8_noise_generator_unit.sv
`timescale 1ns / 1ps

// xoshiro256** noise source giving signed bytes in -63..63. A reseed item
// (tuser 0) loads the four state words from four splitmix64 outputs of
// base_seed + 0x9E37 * (stream_index + 1); it gives no output and keeps
// in_tready low until the last state word is written, since every splitmix64
// output takes two 64-bit products and each product takes three passes
// through the single shared 32 x 32 multiplier. A generate item (tuser 1)
// steps the generator and sends min(byte_count, BYTES_PER_WORD) bytes, low
// byte first, tlast on the final one; in_tready returns in the cycle right
// after the last byte enters the output register. A byte count of zero
// steps the generator and sends nothing. Before the first reseed the state
// is all zero and every byte reads -63.
module xoshiro_int8_noise_generator_unit
  import xng_pkg::*;
#(
  parameter int unsigned BYTES_PER_WORD = BYTES_PER_WORD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data,     // base_seed
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [7:0] stream_index, [11:8] byte_count, [15:12] zero
  input  logic        in_tuser,     // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [6:0] noise_value, [7] zero
  output logic        out_tlast
);

  seq_state_t  state_r, state_nxt;
  logic [63:0] base_seed_r;
  logic [63:0] s0_r, s1_r, s2_r, s3_r;
  logic [24:0] step_r;
  logic [63:0] acc_r;
  logic [63:0] z_r;
  logic [63:0] t_r;
  logic [1:0]  idx_r;
  logic [3:0]  count_r;

  logic        in_xfer;
  logic        mul_run;
  logic        mul_done;
  logic [63:0] mul_b;
  logic [63:0] prod;
  logic [63:0] acc_sum;
  logic [63:0] rot_t;
  logic [63:0] word;
  logic [63:0] s3_x;
  logic        emit_busy;
  emit_req_t   emit_req;
  logic [6:0]  out_noise;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_tvalid && in_tready;
  assign acc_sum   = acc_r + GOLDEN_GAMMA;
  assign rot_t     = {t_r[56:0], t_r[63:57]};
  assign word      = rot_t + {rot_t[60:0], 3'b000};
  assign s3_x      = s3_r ^ s1_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_tuser == MODE_GENERATE) ? ST_ADV : ST_SEED;
        end
      end
      ST_SEED:  state_nxt = ST_MIX;
      ST_MIX:   state_nxt = ST_MUL_A;
      ST_MUL_A: begin
        if (mul_done) begin
          state_nxt = ST_MUL_B;
        end
      end
      ST_MUL_B: begin
        if (mul_done) begin
          state_nxt = (idx_r == 2'd3) ? ST_IDLE : ST_MIX;
        end
      end
      ST_ADV:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready      = (state_r == ST_IDLE) && !emit_busy;
    mul_run        = (state_r == ST_MUL_A) || (state_r == ST_MUL_B);
    mul_b          = (state_r == ST_MUL_A) ? MIX_MUL_A : MIX_MUL_B;
    emit_req.load  = (state_r == ST_ADV);
    emit_req.count = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_seed_r <= '0;
      s0_r        <= '0;
      s1_r        <= '0;
      s2_r        <= '0;
      s3_r        <= '0;
      idx_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        base_seed_r <= cfg_data;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_xfer && (in_tuser == MODE_GENERATE)) begin
            // xoshiro256** state step; the scrambler input uses the old s1.
            s0_r <= s0_r ^ s3_x;
            s1_r <= s1_r ^ s2_r ^ s0_r;
            s2_r <= s2_r ^ s0_r ^ {s1_r[46:0], 17'd0};
            s3_r <= {s3_x[18:0], s3_x[63:19]};
          end
          idx_r <= '0;
        end
        ST_MUL_B: begin
          if (mul_done) begin
            case (idx_r)
              2'd0:    s0_r <= prod ^ (prod >> 31);
              2'd1:    s1_r <= prod ^ (prod >> 31);
              2'd2:    s2_r <= prod ^ (prod >> 31);
              default: s3_r <= prod ^ (prod >> 31);
            endcase
            idx_r <= idx_r + 2'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers that need no reset.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_xfer) begin
      step_r  <= 25'(9'(in_tdata[7:0]) + 9'd1) * 25'(STREAM_STEP);
      t_r     <= s1_r + {s1_r[61:0], 2'b00};
      count_r <= in_tdata[11:8];
    end
    case (state_r)
      ST_SEED: acc_r <= base_seed_r + 64'(step_r);
      ST_MIX: begin
        acc_r <= acc_sum;
        z_r   <= acc_sum ^ (acc_sum >> 30);
      end
      ST_MUL_A: begin
        if (mul_done) begin
          z_r <= prod ^ (prod >> 27);
        end
      end
      default: begin
      end
    endcase
  end

  xng_mul64lo u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .run   (mul_run),
    .a     (z_r),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  xng_emit #(
    .BYTES_PER_WORD (BYTES_PER_WORD)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (emit_req),
    .word       (word),
    .busy       (emit_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_noise  (out_noise),
    .out_tlast  (out_tlast)
  );

  assign out_tdata = {1'b0, out_noise};

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != ST_IDLE))
    else $error("sequencer stayed idle after an input transfer");

  a_mul_done_in_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_MUL_A || state_r == ST_MUL_B))
    else $error("multiplier finished outside a multiply state");

  a_no_emit_during_seed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEED || state_r == ST_MIX || state_r == ST_MUL_A ||
     state_r == ST_MUL_B) |-> !emit_busy)
    else $error("bytes pending while reseeding");

endmodule

// File: tb/tb_xoshiro_int8_noise_generator_unit.sv
`timescale 1ns / 1ps

module tb_xoshiro_int8_noise_generator_unit;
  import xng_pkg::*;

  localparam logic [63:0] SM_GAMMA   = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] SM_MUL_1   = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] SM_MUL_2   = 64'h94D0_49BB_1331_11EB;
  localparam logic [63:0] SEED_STRIDE = 64'h9E37;
  localparam int          WORD_BYTES = 8;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          STALL_LIMIT = 3000;

  typedef struct packed {
    logic       mode;
    logic [7:0] stream;
    logic [3:0] count;
  } noise_req_t;

  typedef struct packed {
    logic [6:0] noise;
    logic       last;
  } noise_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_data = 64'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'd0;   // [7:0] stream_index, [11:8] byte_count, [15:12] zero
  logic        in_tuser = 1'b0;    // mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;          // [6:0] noise_value, [7] zero
  logic        out_tlast;

  noise_req_t  req_q[$];
  noise_byte_t noise_q[$];
  logic [63:0] seed_reg = 64'd0;
  logic [63:0] xs[4] = '{default: 64'd0};
  int          errors = 0;
  int          idle_cycles = 0;
  int          src_gap = 0;
  int          sink_hold = 0;
  bit          in_taken = 1'b0;
  bit          idle_on = 1'b1;

  xoshiro_int8_noise_generator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned n);
    return (v << n) | (v >> (64 - n));
  endfunction

  function automatic logic [63:0] splitmix_out(input logic [63:0] acc);
    logic [63:0] z;
    z = acc;
    z = (z ^ (z >> 30)) * SM_MUL_1;
    z = (z ^ (z >> 27)) * SM_MUL_2;
    return z ^ (z >> 31);
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Updates the generator copy for one accepted item and queues its noise bytes.
  task automatic predict_noise(input noise_req_t r);
    logic [63:0] acc;
    logic [63:0] word;
    logic [63:0] shifted;
    int          n;
    int          v;
    noise_byte_t nb;
    if (r.mode == MODE_RESEED) begin
      acc = seed_reg + SEED_STRIDE * (64'(r.stream) + 64'd1);
      for (int i = 0; i < 4; i++) begin
        acc = acc + SM_GAMMA;
        xs[i] = splitmix_out(acc);
      end
    end else begin
      word = rotl64(xs[1] * 64'd5, 7) * 64'd9;
      shifted = xs[1] << 17;
      xs[2] = xs[2] ^ xs[0];
      xs[3] = xs[3] ^ xs[1];
      xs[1] = xs[1] ^ xs[2];
      xs[0] = xs[0] ^ xs[3];
      xs[2] = xs[2] ^ shifted;
      xs[3] = rotl64(xs[3], 45);
      n = (int'(r.count) > WORD_BYTES) ? WORD_BYTES : int'(r.count);
      for (int k = 0; k < n; k++) begin
        v = int'(word[8*k +: 8]) % 127 - 63;
        nb.noise = v[6:0];
        nb.last = (k == n - 1);
        noise_q.push_back(nb);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_noise(noise_req_t'({in_tuser, in_tdata[7:0], in_tdata[11:8]}));
      in_taken = 1'b1;
    end
  end

  // Source side: holds an item until its transfer, then waits out its gap.
  always @(negedge clk) begin
    noise_req_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (src_gap > 0) begin
        src_gap--;
        in_tvalid <= 1'b0;
      end else if (req_q.size() > 0) begin
        r = req_q.pop_front();
        in_tuser <= r.mode;
        in_tdata <= {4'd0, r.count, r.stream};
        in_tvalid <= 1'b1;
        src_gap = idle_on ? draw_gap() : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  always @(negedge clk) begin
    if (idle_on && sink_hold > 0) begin
      sink_hold--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 3) == 0) sink_hold = draw_gap();
    end
  end

  always @(posedge clk) begin
    noise_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (noise_q.size() == 0) begin
        $display("%0t: unexpected noise byte, actual tdata=%h tlast=%b",
                 $time, out_tdata, out_tlast);
        errors++;
      end else begin
        want = noise_q.pop_front();
        if (out_tdata !== {1'b0, want.noise} || out_tlast !== want.last) begin
          $display("%0t: noise mismatch, expected tdata=%h tlast=%b, actual tdata=%h tlast=%b",
                   $time, {1'b0, want.noise}, want.last, out_tdata, out_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic push_req(input logic mode, input logic [7:0] stream, input logic [3:0] count);
    req_q.push_back('{mode: mode, stream: stream, count: count});
  endtask

  // A reseed or an empty generate can still be in progress when the last byte
  // arrives, so let the block settle before touching the seed.
  task automatic wait_drained();
    while (req_q.size() > 0 || in_tvalid || noise_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [63:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    seed_reg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic push_random(input int n);
    logic [3:0] cnt;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) cnt = 4'($urandom_range(9, 15));
      else if ($urandom_range(0, 19) == 0) cnt = 4'd0;
      else cnt = 4'($urandom_range(1, 8));
      push_req(($urandom_range(0, 99) < 15) ? MODE_RESEED : MODE_GENERATE,
               8'($urandom_range(0, 255)), cnt);
    end
  endtask

  initial begin
    logic [63:0] seeds[5];
    seeds[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    seeds[1] = 64'd0;
    seeds[2] = 64'h8000_0000_0000_0000;
    seeds[3] = {$urandom(), $urandom()};
    seeds[4] = {$urandom(), $urandom()};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero state before any reseed, empty and oversized counts,
    // extreme stream numbers, and a stream number that generate must ignore.
    push_req(MODE_GENERATE, 8'h00, 4'd8);
    push_req(MODE_GENERATE, 8'hFF, 4'd0);
    push_req(MODE_GENERATE, 8'h00, 4'd15);
    push_req(MODE_RESEED,   8'h00, 4'd0);
    push_req(MODE_GENERATE, 8'h00, 4'd8);
    push_req(MODE_GENERATE, 8'h00, 4'd1);
    push_req(MODE_RESEED,   8'hFF, 4'd15);
    push_req(MODE_GENERATE, 8'hAA, 4'd8);
    push_req(MODE_GENERATE, 8'h55, 4'd9);
    push_req(MODE_GENERATE, 8'h00, 4'd0);
    for (int c = 1; c <= 8; c++) push_req(MODE_GENERATE, 8'h00, 4'(c));
    push_req(MODE_RESEED,   8'h80, 4'd8);
    push_req(MODE_GENERATE, 8'h7F, 4'd8);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      write_seed(seeds[p]);
      idle_on = (p != 1);
      push_req(MODE_RESEED, 8'($urandom_range(0, 255)), 4'd8);
      push_random(80);
      wait_drained();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/xng_pkg.sv
rtl/xng_mul64lo.sv
rtl/xng_emit.sv
rtl/xoshiro_int8_noise_generator_unit.sv
tb/tb_xoshiro_int8_noise_generator_unit.sv
